// ===== rtl/segment_closest_points_capsule_test_defines.svh =====
// ----------------------------------------------------------------------------
// segment_closest_points_capsule_test_defines
// Assertion macros shared by the closest-point pipeline. Each macro expects
// clk and rst to be in scope.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_CLOSEST_POINTS_CAPSULE_TEST_DEFINES_SVH
`define SEGMENT_CLOSEST_POINTS_CAPSULE_TEST_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define SCPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scpc: implication check failed");

// Next-cycle implication, also checked across reset.
`define SCPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("scpc: next-cycle check failed");

`endif

// ===== rtl/scpc_pkg.sv =====
// ----------------------------------------------------------------------------
// scpc_pkg
// Widths, types and constants of the segment closest-point pipeline.
// ----------------------------------------------------------------------------
package scpc_pkg;

  localparam int COORD_W   = 24;  // Q16.8 coordinate
  localparam int DIFF_W    = 25;  // difference of two coordinates
  localparam int DOT_W     = 50;  // signed dot product, magnitude below 2^49
  localparam int MAG_W     = 49;  // dot product magnitude
  localparam int LO_W      = 25;  // low slice of a split operand
  localparam int HI_W      = MAG_W - LO_W;
  localparam int PROD_W    = 99;  // signed product of two dot products
  localparam int DIV1_W    = 101; // first divider operand width
  localparam int TN_W      = 68;  // t numerator and second divider width
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int PT_W      = 43;  // coordinate difference times parameter
  localparam int GAP_W     = 49;  // exact squared gap
  localparam int BW_W      = 48;  // width squared register and gap output
  localparam int DIV_LAT   = FRAC_BITS + 1;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;
  localparam logic [BW_W-1:0]   BW_RESET = BW_W'(65536);
  localparam logic [BW_W-1:0]   GAP_MAX  = '1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic [FRAC_W-1:0]         frac_t;

  // Endpoints used as bases and the two direction vectors.
  typedef struct packed {
    coord_t a1x;
    coord_t a1y;
    coord_t b1x;
    coord_t b1y;
    diff_t  d1x;
    diff_t  d1y;
    diff_t  d2x;
    diff_t  d2y;
  } geo_t;

  // Dot products of the directions and the base offset.
  typedef struct packed {
    dot_t a;
    dot_t b;
    dot_t c;
    dot_t e;
    dot_t f;
    logic e_zero;
  } dots_t;

endpackage

// ===== rtl/segment_closest_points_capsule_test.sv =====
// ----------------------------------------------------------------------------
// segment_closest_points_capsule_test
// Closest points between two 2D segments with capsule contact flags.
// ----------------------------------------------------------------------------
// The block accepts one segment pair per clock when not stalled and returns
// one result per pair. The pipeline holds 18 ordinary stages and two 17-stage
// dividers (entry clamp, then one restoring quotient bit per stage): the
// first finds the unclamped-region parameter s, the second finds either t
// or the re-clamped s. When the output transaction is stalled the whole
// pipeline holds, so no item is lost or repeated. The width squared register
// is written through cfg_we/cfg_wdata and should only change while idle.
`include "segment_closest_points_capsule_test_defines.svh"

module segment_closest_points_capsule_test (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [47:0]   cfg_wdata,    // body_width_squared
  input  logic          s_tvalid,
  output logic          s_tready,
  // seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
  // seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y (24 bits each)
  input  logic [191:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // near_a_x, near_a_y, near_b_x, near_b_y (24 bits each), gap_squared (48),
  // bodies_touch, probe_hits, then 6 zero bits
  output logic [151:0]  m_tdata
);
  import scpc_pkg::*;

  logic en;
  logic [BW_W-1:0] body_width_squared;

  // Whole pipeline advances unless the output register is stalled.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Width squared register.
  always_ff @(posedge clk) begin
    if (rst) begin
      body_width_squared <= BW_RESET;
    end else if (cfg_we) begin
      body_width_squared <= cfg_wdata;
    end
  end

  // Valid bits of the ordinary stages.
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12;
  logic v13, v14, v15, v16, v17;
  logic [DIV_LAT-1:0] dv1, dv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12} <= '0;
      {v13, v14, v15, v16, v17, m_tvalid} <= '0;
      dv1 <= '0;
      dv2 <= '0;
    end else if (en) begin
      v1  <= s_tvalid;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      dv1 <= {dv1[DIV_LAT-2:0], v8};
      v9  <= dv1[DIV_LAT-1];
      v10 <= v9;
      v11 <= v10;
      v12 <= v11;
      dv2 <= {dv2[DIV_LAT-2:0], v12};
      v13 <= dv2[DIV_LAT-1];
      v14 <= v13;
      v15 <= v14;
      v16 <= v15;
      v17 <= v16;
      m_tvalid <= v17;
    end
  end

  // Stage 1: field unpacking and direction vectors.
  coord_t in_a0x, in_a0y, in_a1x, in_a1y, in_b0x, in_b0y, in_b1x, in_b1y;
  geo_t   g1;
  diff_t  r1x, r1y;

  assign in_a0x = s_tdata[23:0];
  assign in_a0y = s_tdata[47:24];
  assign in_a1x = s_tdata[71:48];
  assign in_a1y = s_tdata[95:72];
  assign in_b0x = s_tdata[119:96];
  assign in_b0y = s_tdata[143:120];
  assign in_b1x = s_tdata[167:144];
  assign in_b1y = s_tdata[191:168];

  always_ff @(posedge clk) begin
    if (en) begin
      g1.a1x <= in_a1x;
      g1.a1y <= in_a1y;
      g1.b1x <= in_b1x;
      g1.b1y <= in_b1y;
      g1.d1x <= diff_t'(in_a0x) - diff_t'(in_a1x);
      g1.d1y <= diff_t'(in_a0y) - diff_t'(in_a1y);
      g1.d2x <= diff_t'(in_b0x) - diff_t'(in_b1x);
      g1.d2y <= diff_t'(in_b0y) - diff_t'(in_b1y);
      r1x    <= diff_t'(in_a1x) - diff_t'(in_b1x);
      r1y    <= diff_t'(in_a1y) - diff_t'(in_b1y);
    end
  end

  // Stage 2: component products of the five dot products.
  geo_t g2;
  dot_t p_aa_x, p_aa_y, p_ab_x, p_ab_y, p_ee_x, p_ee_y;
  dot_t p_c_x, p_c_y, p_f_x, p_f_y;

  always_ff @(posedge clk) begin
    if (en) begin
      g2     <= g1;
      p_aa_x <= g1.d1x * g1.d1x;
      p_aa_y <= g1.d1y * g1.d1y;
      p_ab_x <= g1.d1x * g1.d2x;
      p_ab_y <= g1.d1y * g1.d2y;
      p_ee_x <= g1.d2x * g1.d2x;
      p_ee_y <= g1.d2y * g1.d2y;
      p_c_x  <= g1.d1x * r1x;
      p_c_y  <= g1.d1y * r1y;
      p_f_x  <= g1.d2x * r1x;
      p_f_y  <= g1.d2y * r1y;
    end
  end

  // Stage 3: dot products.
  geo_t  g3;
  dots_t d3;

  always_ff @(posedge clk) begin
    if (en) begin
      g3        <= g2;
      d3.a      <= p_aa_x + p_aa_y;
      d3.b      <= p_ab_x + p_ab_y;
      d3.e      <= p_ee_x + p_ee_y;
      d3.c      <= p_c_x + p_c_y;
      d3.f      <= p_f_x + p_f_y;
      d3.e_zero <= ((p_ee_x + p_ee_y) == '0);
    end
  end

  // Stage 4: magnitudes and signs for a*e, b*b, b*f, c*e.
  geo_t  g4;
  dots_t d4;
  dot_t  op_x [4];
  dot_t  op_y [4];
  logic [MAG_W-1:0] mx4 [4];
  logic [MAG_W-1:0] my4 [4];
  logic [3:0]       sg4;

  always_comb begin
    op_x[0] = d3.a;  op_y[0] = d3.e;
    op_x[1] = d3.b;  op_y[1] = d3.b;
    op_x[2] = d3.b;  op_y[2] = d3.f;
    op_x[3] = d3.c;  op_y[3] = d3.e;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g4 <= g3;
      d4 <= d3;
      for (int k = 0; k < 4; k++) begin
        mx4[k] <= op_x[k][DOT_W-1] ? MAG_W'(-op_x[k]) : MAG_W'(op_x[k]);
        my4[k] <= op_y[k][DOT_W-1] ? MAG_W'(-op_y[k]) : MAG_W'(op_y[k]);
        sg4[k] <= op_x[k][DOT_W-1] ^ op_y[k][DOT_W-1];
      end
    end
  end

  // Stage 5: partial products of the split magnitudes.
  geo_t  g5;
  dots_t d5;
  logic [3:0] sg5;
  logic [2*LO_W-1:0]      pll [4];
  logic [LO_W+HI_W-1:0]   plh [4];
  logic [LO_W+HI_W-1:0]   phl [4];
  logic [2*HI_W-1:0]      phh [4];

  always_ff @(posedge clk) begin
    if (en) begin
      g5  <= g4;
      d5  <= d4;
      sg5 <= sg4;
      for (int k = 0; k < 4; k++) begin
        pll[k] <= mx4[k][LO_W-1:0] * my4[k][LO_W-1:0];
        plh[k] <= mx4[k][LO_W-1:0] * my4[k][MAG_W-1:LO_W];
        phl[k] <= mx4[k][MAG_W-1:LO_W] * my4[k][LO_W-1:0];
        phh[k] <= mx4[k][MAG_W-1:LO_W] * my4[k][MAG_W-1:LO_W];
      end
    end
  end

  // Stage 6: cross terms summed.
  geo_t  g6;
  dots_t d6;
  logic [3:0] sg6;
  logic [2*LO_W-1:0]    ll6  [4];
  logic [LO_W+HI_W:0]   mid6 [4];
  logic [2*HI_W-1:0]    hh6  [4];

  always_ff @(posedge clk) begin
    if (en) begin
      g6  <= g5;
      d6  <= d5;
      sg6 <= sg5;
      for (int k = 0; k < 4; k++) begin
        ll6[k]  <= pll[k];
        hh6[k]  <= phh[k];
        mid6[k] <= (LO_W+HI_W+1)'(plh[k]) + (LO_W+HI_W+1)'(phl[k]);
      end
    end
  end

  // Stage 7: full signed products.
  geo_t  g7;
  dots_t d7;
  logic [PROD_W-1:0] mag7 [4];
  logic signed [PROD_W-1:0] pr7 [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag7[k] = (PROD_W'(hh6[k]) << (2*LO_W)) + (PROD_W'(mid6[k]) << LO_W)
                + PROD_W'(ll6[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g7 <= g6;
      d7 <= d6;
      for (int k = 0; k < 4; k++) begin
        pr7[k] <= sg6[k] ? -$signed(mag7[k]) : $signed(mag7[k]);
      end
    end
  end

  // Stage 8: denominator a*e - b*b and numerator b*f - c*e.
  geo_t  g8;
  dots_t d8;
  logic signed [DIV1_W-1:0] den8, num8;

  always_ff @(posedge clk) begin
    if (en) begin
      g8   <= g7;
      d8   <= d7;
      den8 <= DIV1_W'(pr7[0]) - DIV1_W'(pr7[1]);
      num8 <= DIV1_W'(pr7[2]) - DIV1_W'(pr7[3]);
    end
  end

  // First divider: s for the unclamped case, with its side data.
  frac_t q1;
  geo_t  sg_d1 [DIV_LAT];
  dots_t sd_d1 [DIV_LAT];

  scpc_frac_div #(.W(DIV1_W)) u_div_s (
    .clk (clk),
    .en  (en),
    .n   (num8),
    .m   (den8),
    .fz  (den8 == '0),
    .q   (q1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sg_d1[0] <= g8;
      sd_d1[0] <= d8;
      for (int i = 1; i < DIV_LAT; i++) begin
        sg_d1[i] <= sg_d1[i-1];
        sd_d1[i] <= sd_d1[i-1];
      end
    end
  end

  // Stage 9: s clamped, partial products of |b| * s.
  geo_t  g9;
  dots_t d9;
  frac_t s9, s_first;
  logic [MAG_W-1:0] bm;
  logic [LO_W+FRAC_W-1:0] bs_lo9;
  logic [HI_W+FRAC_W-1:0] bs_hi9;
  logic bneg9;

  assign s_first = sd_d1[DIV_LAT-1].e_zero ? '0 : q1;
  assign bm = sd_d1[DIV_LAT-1].b[DOT_W-1] ? MAG_W'(-sd_d1[DIV_LAT-1].b)
                                          : MAG_W'(sd_d1[DIV_LAT-1].b);

  always_ff @(posedge clk) begin
    if (en) begin
      g9     <= sg_d1[DIV_LAT-1];
      d9     <= sd_d1[DIV_LAT-1];
      s9     <= s_first;
      bneg9  <= sd_d1[DIV_LAT-1].b[DOT_W-1];
      bs_lo9 <= bm[LO_W-1:0] * s_first;
      bs_hi9 <= bm[MAG_W-1:LO_W] * s_first;
    end
  end

  // Stage 10: b * s as a signed value.
  geo_t  g10;
  dots_t d10;
  frac_t s10;
  logic [TN_W-1:0] bs_mag;
  logic signed [TN_W-1:0] bs10;

  assign bs_mag = (TN_W'(bs_hi9) << LO_W) + TN_W'(bs_lo9);

  always_ff @(posedge clk) begin
    if (en) begin
      g10  <= g9;
      d10  <= d9;
      s10  <= s9;
      bs10 <= bneg9 ? -$signed(bs_mag) : $signed(bs_mag);
    end
  end

  // Stage 11: t numerator and the candidate re-clamp numerators.
  geo_t  g11;
  dots_t d11;
  frac_t s11;
  logic signed [TN_W-1:0] tn11, e16_11, negc11, bmc11;

  always_ff @(posedge clk) begin
    if (en) begin
      g11    <= g10;
      d11    <= d10;
      s11    <= s10;
      tn11   <= bs10 + (TN_W'(d10.f) <<< FRAC_BITS);
      e16_11 <= TN_W'(d10.e) <<< FRAC_BITS;
      negc11 <= -TN_W'(d10.c);
      bmc11  <= TN_W'(d10.b) - TN_W'(d10.c);
    end
  end

  // Stage 12: region select, operands of the second divider.
  geo_t  g12;
  frac_t s12, tfix12;
  logic  mid12, fz12;
  logic signed [TN_W-1:0] n12, m12;
  logic  t_neg, t_over, a_zero11;

  assign t_neg    = tn11[TN_W-1] || d11.e_zero;
  assign t_over   = !t_neg && (tn11 > e16_11);
  assign a_zero11 = (d11.a == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      g12    <= g11;
      s12    <= s11;
      mid12  <= !t_neg && !t_over;
      tfix12 <= t_over ? FRAC_ONE : '0;
      if (t_neg) begin
        n12  <= negc11;
        m12  <= TN_W'(d11.a);
        fz12 <= a_zero11;
      end else if (t_over) begin
        n12  <= bmc11;
        m12  <= TN_W'(d11.a);
        fz12 <= a_zero11;
      end else begin
        n12  <= tn11;
        m12  <= e16_11;
        fz12 <= 1'b0;
      end
    end
  end

  // Second divider: t, or s re-clamped on an edge of segment B.
  frac_t q2;
  geo_t  sg_d2  [DIV_LAT];
  frac_t ss_d2  [DIV_LAT];
  frac_t st_d2  [DIV_LAT];
  logic [DIV_LAT-1:0] sm_d2;

  scpc_frac_div #(.W(TN_W)) u_div_t (
    .clk (clk),
    .en  (en),
    .n   (n12),
    .m   (m12),
    .fz  (fz12),
    .q   (q2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sg_d2[0] <= g12;
      ss_d2[0] <= s12;
      st_d2[0] <= tfix12;
      sm_d2    <= {sm_d2[DIV_LAT-2:0], mid12};
      for (int i = 1; i < DIV_LAT; i++) begin
        sg_d2[i] <= sg_d2[i-1];
        ss_d2[i] <= ss_d2[i-1];
        st_d2[i] <= st_d2[i-1];
      end
    end
  end

  // Stage 13: final parameters and direction offsets.
  frac_t s_sel, t_sel;
  geo_t  g13;
  logic signed [PT_W-1:0] pax, pay, pbx, pby;

  assign s_sel = sm_d2[DIV_LAT-1] ? ss_d2[DIV_LAT-1] : q2;
  assign t_sel = sm_d2[DIV_LAT-1] ? q2 : st_d2[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      g13 <= sg_d2[DIV_LAT-1];
      pax <= sg_d2[DIV_LAT-1].d1x * $signed({1'b0, s_sel});
      pay <= sg_d2[DIV_LAT-1].d1y * $signed({1'b0, s_sel});
      pbx <= sg_d2[DIV_LAT-1].d2x * $signed({1'b0, t_sel});
      pby <= sg_d2[DIV_LAT-1].d2y * $signed({1'b0, t_sel});
    end
  end

  // Stage 14: offsets rounded to Q16.8 (ties up) and added to the bases.
  localparam int RND_W = PT_W - FRAC_BITS;
  localparam logic signed [PT_W-1:0] HALF = PT_W'(1) << (FRAC_BITS - 1);
  logic signed [RND_W-1:0] rax, ray, rbx, rby;
  coord_t nax, nay, nbx, nby;

  assign rax = RND_W'((pax + HALF) >>> FRAC_BITS);
  assign ray = RND_W'((pay + HALF) >>> FRAC_BITS);
  assign rbx = RND_W'((pbx + HALF) >>> FRAC_BITS);
  assign rby = RND_W'((pby + HALF) >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      nax <= COORD_W'(RND_W'(g13.a1x) + rax);
      nay <= COORD_W'(RND_W'(g13.a1y) + ray);
      nbx <= COORD_W'(RND_W'(g13.b1x) + rbx);
      nby <= COORD_W'(RND_W'(g13.b1y) + rby);
    end
  end

  // Stage 15: separation vector.
  coord_t nax15, nay15, nbx15, nby15;
  diff_t  dx15, dy15;

  always_ff @(posedge clk) begin
    if (en) begin
      nax15 <= nax;
      nay15 <= nay;
      nbx15 <= nbx;
      nby15 <= nby;
      dx15  <= diff_t'(nax) - diff_t'(nbx);
      dy15  <= diff_t'(nay) - diff_t'(nby);
    end
  end

  // Stage 16: squared components.
  coord_t nax16, nay16, nbx16, nby16;
  dot_t   sqx16, sqy16;

  always_ff @(posedge clk) begin
    if (en) begin
      nax16 <= nax15;
      nay16 <= nay15;
      nbx16 <= nbx15;
      nby16 <= nby15;
      sqx16 <= dx15 * dx15;
      sqy16 <= dy15 * dy15;
    end
  end

  // Stage 17: exact squared gap.
  coord_t nax17, nay17, nbx17, nby17;
  logic [GAP_W-1:0] gap17;

  always_ff @(posedge clk) begin
    if (en) begin
      nax17 <= nax16;
      nay17 <= nay16;
      nbx17 <= nbx16;
      nby17 <= nby16;
      gap17 <= GAP_W'(sqx16) + GAP_W'(sqy16);
    end
  end

  // Output register: saturation and contact flags.
  logic [BW_W-1:0] gap_out;
  logic touch, probe;

  assign gap_out = gap17[GAP_W-1] ? GAP_MAX : gap17[BW_W-1:0];
  assign touch   = gap17 <= GAP_W'(body_width_squared);
  assign probe   = {gap17, 2'b00} <= (GAP_W+2)'(body_width_squared);

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {6'b0, probe, touch, gap_out, nby17, nbx17, nay17, nax17};
    end
  end

  // Checks on the pipeline.
  `SCPC_ASSERT_NXT(a_reset_idle, rst, !m_tvalid && !v17 && !v1)
  `SCPC_ASSERT_IMP(a_probe_in_touch, m_tvalid, !m_tdata[145] || m_tdata[144])
  `SCPC_ASSERT_IMP(a_param_range, dv2[DIV_LAT-1],
                   (s_sel <= FRAC_ONE) && (t_sel <= FRAC_ONE))
  `SCPC_ASSERT_IMP(a_stall_holds, m_tvalid && !m_tready, !s_tready)

endmodule

// ===== rtl/scpc_frac_div.sv =====
// ----------------------------------------------------------------------------
// scpc_frac_div
// Pipelined clamped fraction divider: q = clamp(n / m) in unsigned Q1.16,
// clamp decisions at entry, then one restoring step per stage.
// ----------------------------------------------------------------------------
module scpc_frac_div #(
  parameter int W = scpc_pkg::DIV1_W
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  n,
  input  logic signed [W-1:0]  m,
  input  logic                 fz,
  output scpc_pkg::frac_t      q
);
  import scpc_pkg::*;

  logic [W-1:0]           rem   [FRAC_BITS+1];
  logic [W-1:0]           den   [FRAC_BITS+1];
  logic [FRAC_BITS-1:0]   quo   [FRAC_BITS+1];
  logic [FRAC_BITS:0]     zr;
  logic [FRAC_BITS:0]     on;
  logic [W-1:0]           shl   [FRAC_BITS];
  logic [FRAC_BITS-1:0]   ge;

  // One restoring step per stage; the remainder stays below the divisor.
  always_comb begin
    for (int i = 0; i < FRAC_BITS; i++) begin
      shl[i] = {rem[i][W-2:0], 1'b0};
      ge[i]  = (shl[i] >= den[i]);
    end
  end

  // Clamp decisions at entry, then the step pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      zr[0]  <= fz || (n <= 0);
      on[0]  <= !(fz || (n <= 0)) && (n >= m);
      rem[0] <= n;
      den[0] <= m;
      quo[0] <= '0;
      for (int i = 0; i < FRAC_BITS; i++) begin
        zr[i+1]  <= zr[i];
        on[i+1]  <= on[i];
        den[i+1] <= den[i];
        rem[i+1] <= ge[i] ? (shl[i] - den[i]) : shl[i];
        quo[i+1] <= {quo[i][FRAC_BITS-2:0], ge[i]};
      end
    end
  end

  assign q = zr[FRAC_BITS] ? '0 :
             on[FRAC_BITS] ? FRAC_ONE : {1'b0, quo[FRAC_BITS]};

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the segment closest-point pipeline. Segment pairs are
// sent as stream transactions; each result is checked against a predictor of
// the clamped-parameter closest-point method at the block's fixed-point
// widths. Directed cases, random cases, idling and backpressure phases.
// ----------------------------------------------------------------------------
module testbench;
  import scpc_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [47:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [151:0] m_tdata;

  localparam int LATENCY = 52;

  segment_closest_points_capsule_test i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  logic [151:0] expected_results[$];
  logic [47:0]  width_sq = 48'd65536;
  int           errors = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_off = 0;
  longint       cycles = 0;

  // Clamped quotient n/m in Q1.16, m > 0.
  function automatic logic [16:0] clamp_quot(logic signed [127:0] n,
                                             logic signed [127:0] m);
    logic [16:0] q;
    q = '0;
    if (n <= 0) return 17'd0;
    if (n >= m) return 17'd65536;
    for (int i = 0; i < 16; i++) begin
      n = n <<< 1;
      q = q << 1;
      if (n >= m) begin
        n = n - m;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [16:0] quot_over_a(logic signed [127:0] n,
                                              logic signed [127:0] a);
    return (a > 0) ? clamp_quot(n, a) : 17'd0;
  endfunction

  // Round to nearest Q16.8 offset, ties toward plus infinity.
  function automatic logic signed [63:0] round_frac(logic signed [63:0] v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic [151:0] predict_closest(logic [191:0] d,
                                                   logic [47:0] wsq);
    logic signed [63:0] a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y;
    logic signed [63:0] d1x, d1y, d2x, d2y, rx, ry, nax, nay, nbx, nby, dx, dy;
    logic signed [127:0] a, b, c, e, f, den, tn;
    logic [16:0] s, t;
    logic [63:0] gap;
    logic [47:0] gap_out;
    a0x = coord_t'(d[23:0]);     a0y = coord_t'(d[47:24]);
    a1x = coord_t'(d[71:48]);    a1y = coord_t'(d[95:72]);
    b0x = coord_t'(d[119:96]);   b0y = coord_t'(d[143:120]);
    b1x = coord_t'(d[167:144]);  b1y = coord_t'(d[191:168]);
    d1x = a0x - a1x; d1y = a0y - a1y;
    d2x = b0x - b1x; d2y = b0y - b1y;
    rx = a1x - b1x;  ry = a1y - b1y;
    a = d1x * d1x + d1y * d1y;
    b = d1x * d2x + d1y * d2y;
    e = d2x * d2x + d2y * d2y;
    c = d1x * rx + d1y * ry;
    f = d2x * rx + d2y * ry;
    if (e == 0) begin
      t = 0;
      s = quot_over_a(-c, a);
    end else begin
      den = a * e - b * b;
      s = (den == 0) ? 17'd0 : clamp_quot(b * f - c * e, den);
      tn = b * $signed({111'd0, s}) + (f <<< 16);
      if (tn < 0) begin
        t = 0;
        s = quot_over_a(-c, a);
      end else if (tn > (e <<< 16)) begin
        t = 17'd65536;
        s = quot_over_a(b - c, a);
      end else begin
        t = clamp_quot(tn, e <<< 16);
      end
    end
    nax = a1x + round_frac(d1x * $signed({47'd0, s}));
    nay = a1y + round_frac(d1y * $signed({47'd0, s}));
    nbx = b1x + round_frac(d2x * $signed({47'd0, t}));
    nby = b1y + round_frac(d2y * $signed({47'd0, t}));
    dx = nax - nbx; dy = nay - nby;
    gap = dx * dx + dy * dy;
    gap_out = (gap > 64'hFFFF_FFFF_FFFF) ? GAP_MAX : gap[47:0];
    return {6'd0, (gap * 4 <= wsq), (gap <= wsq), gap_out,
            nby[23:0], nbx[23:0], nay[23:0], nax[23:0]};
  endfunction

  // Sender: offers one pair and waits for its transaction. The valid stays
  // up afterwards; the next call or drain() decides its next value.
  task automatic send_pair(logic [191:0] d);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    expected_results.push_back(predict_closest(d, width_sq));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_width(logic [47:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    width_sq = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(2047)) - 24'd1024;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [191:0] rand_pair();
    logic [191:0] d;
    for (int i = 0; i < 8; i++) d[i*24 +: 24] = rand_coord();
    // Degenerate and parallel shapes now and then.
    case ($urandom_range(9))
      0: d[71:48] = d[23:0];
      1: d[191:144] = d[143:96];
      2: begin
        d[71:0] = {d[47:24], d[23:0], d[23:0]};
        d[95:72] = d[47:24];
      end
      3: begin
        d[119:96] = d[23:0] + 24'd512; d[143:120] = d[47:24];
        d[167:144] = d[71:48] + 24'd512; d[191:168] = d[95:72];
      end
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [191:0] pack8(int v[8]);
    logic [191:0] d;
    for (int i = 0; i < 8; i++) d[i*24 +: 24] = 24'(v[i]);
    return d;
  endfunction

  // Extremes, crossing, parallel and zero-length segments.
  task automatic test_directed();
    send_pair('0);
    send_pair({8{24'h7FFFFF}});
    send_pair({8{24'h800000}});
    send_pair({4{24'h800000, 24'h7FFFFF}});
    send_pair({{4{24'h7FFFFF}}, {4{24'h800000}}});
    send_pair(pack8('{0, 0, 2560, 0, 1280, -1280, 1280, 1280}));
    send_pair(pack8('{0, 0, 2560, 0, 0, 256, 2560, 256}));
    send_pair(pack8('{0, 0, 2560, 0, 0, 64, 2560, 64}));
    send_pair(pack8('{300, 300, 300, 300, 0, 0, 1000, 0}));
    send_pair(pack8('{0, 0, 1000, 0, 500, 100, 500, 100}));
    send_pair(pack8('{7, 7, 7, 7, 9, 9, 9, 9}));
    send_pair(pack8('{0, 0, 256, 0, 1024, 0, 2048, 0}));
    send_pair(pack8('{0, 0, 256, 0, -2048, 10, -1024, 10}));
    send_pair(pack8('{-8388608, 8388607, 8388607, -8388608,
                      8388607, 8388607, -8388608, -8388608}));
    send_pair(pack8('{0, 0, 3, 1, 1, 0, 2, 1}));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_pair(rand_pair());
  endtask

  // Long receiver hold-off while the sender keeps offering pairs.
  task automatic test_backpressure();
    hold_off = 300;
    test_random(120);
    drain();
  endtask

  // Receiver stalls, counted in its own process.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        errors <= errors + 1;
      end else if (m_tdata !== expected_results[0]) begin
        $display("%0t: mismatch expected %h actual %h", $time,
                 expected_results[0], m_tdata);
        errors <= errors + 1;
        void'(expected_results.pop_front());
      end else begin
        void'(expected_results.pop_front());
      end
    end
    if (cycles > 2000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_width(48'd0);
    test_directed();
    write_width(GAP_MAX);
    test_random(150);
    write_width(48'd1 << 40);
    send_idle_pct = 73;
    test_random(150);
    send_idle_pct = 0;
    recv_stall_pct = 73;
    write_width(48'($urandom) << 12);
    test_random(150);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    write_width(48'd65536);
    test_random(150);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    write_width({$urandom, 16'($urandom)});
    test_random(180);
    drain();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
